@@ rtl/core/wildcard_glob_matcher_defines.svh @@
// Assertion macros shared by the glob matcher checker.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define WGM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("glob matcher assertion failed");

// Clocked assertion that is also checked while reset is high.
`define WGM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("glob matcher assertion failed");

`endif

@@ rtl/core/wgm_pkg.sv @@
// Package of types, constants and helper functions for the glob matcher.
package wgm_pkg;

   // Pattern capacity and the widths that follow from it.
   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int ACT_W       = MAX_PATTERN + 1;

   // Special pattern characters and the case folding range.
   localparam logic [7:0] GLOB_STAR   = 8'h2A;
   localparam logic [7:0] GLOB_ANY    = 8'h3F;
   localparam logic [7:0] FOLD_LO     = 8'h41;
   localparam logic [7:0] FOLD_HI     = 8'h5A;
   localparam logic [7:0] FOLD_OFFSET = 8'h20;

   // Request operations.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // What the pattern store tells the matcher about the pattern.
   typedef struct packed {
      logic [LEN_W-1:0]       length;
      logic                   overflow;
      logic [MAX_PATTERN-1:0] star_now;
      logic [MAX_PATTERN-1:0] hit_now;
      logic [MAX_PATTERN-1:0] star_next;
   } pat_status_type;

   // Fold ASCII upper case letters to lower case.
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= FOLD_LO && b <= FOLD_HI) begin
         r = b + FOLD_OFFSET;
      end
      return r;
   endfunction

   // Close a position set over stars. An active star position also activates
   // the next one, and runs of stars chain along. This is a carry chain: the
   // star mask propagates, an active star generates, so one adder does it.
   function automatic logic [ACT_W-1:0] star_closure(input logic [ACT_W-1:0]       seed,
                                                    input logic [MAX_PATTERN-1:0] star);
      logic [ACT_W:0] a;
      logic [ACT_W:0] b;
      logic [ACT_W:0] sum;
      logic [ACT_W:0] carry;
      a     = {2'b00, star};
      b     = {1'b0, seed} & a;
      sum   = a + b;
      carry = sum ^ a ^ b;
      return seed | carry[ACT_W-1:0];
   endfunction

endpackage

@@ rtl/core/wgm_pattern.sv @@
// Pattern store with length and overflow tracking and per-position compare.
module wgm_pattern (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    upd,
   input  wgm_pkg::req_type        req,
   output wgm_pkg::pat_status_type status
);
   import wgm_pkg::*;

   logic [7:0]             pat_ff [MAX_PATTERN];
   logic [7:0]             pat_in [MAX_PATTERN];
   logic [LEN_W-1:0]       len_ff;
   logic [LEN_W-1:0]       len_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic                   room;
   logic                   is_app;
   logic [7:0]             ch_fold;
   logic [MAX_PATTERN-1:0] wr_sel;
   logic [MAX_PATTERN-1:0] star_now;
   logic [MAX_PATTERN-1:0] hit_now;
   logic [MAX_PATTERN-1:0] star_next;

   // Decode of the request being applied this cycle.
   assign ch_fold = fold_case(req.char_byte);
   assign room    = (len_ff < LEN_W'(MAX_PATTERN));
   assign is_app  = upd && (req.operation == OP_APPEND);

   // Next length and overflow flag.
   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (upd) begin
         unique case (req.operation)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
            end
            OP_APPEND: begin
               if (room) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            OP_TEXT, OP_END: begin
               len_in = len_ff;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   // Each position compares its own stored byte in parallel.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
      logic in_now;
      logic in_next;
      assign in_now    = (LEN_W'(i) < len_ff);
      assign in_next   = (LEN_W'(i) < len_in);
      assign wr_sel[i] = is_app && room && (len_ff == LEN_W'(i));
      assign pat_in[i] = wr_sel[i] ? ch_fold : pat_ff[i];
      assign star_now[i]  = in_now && (pat_ff[i] == GLOB_STAR);
      assign star_next[i] = in_next && (pat_in[i] == GLOB_STAR);
      assign hit_now[i]   = in_now && (pat_ff[i] != GLOB_STAR) &&
                            ((pat_ff[i] == GLOB_ANY) || (pat_ff[i] == ch_fold));
   end

   // Stored bytes are held folded; '*' and '?' are unaffected by folding.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_ff[i] <= pat_in[i];
      end
   end

   // Length and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   assign status.length    = len_ff;
   assign status.overflow  = ovf_ff;
   assign status.star_now  = star_now;
   assign status.hit_now   = hit_now;
   assign status.star_next = star_next;

endmodule

@@ rtl/core/wildcard_glob_matcher.sv @@
// Timing: a request is registered at acceptance and applied from the request register;
// an end of text result passes from the request register into the response register.
// Throughput: one request per cycle; only an end of text waits in the request register
// while an earlier result is not taken. One adder does the star closure.
// Reset: synchronous; empties the pattern, clears overflow and both valid stages.
// Top level of the case-insensitive glob matcher.
module wildcard_glob_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wgm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wgm_pkg::rsp_type rsp_payload
);
   import wgm_pkg::*;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_type        s1_req_ff;
   req_type        s1_req_in;
   logic [ACT_W-1:0] act_ff;
   logic [ACT_W-1:0] act_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           s1_is_end;
   logic           s1_go;
   logic           accept;
   logic [ACT_W-1:0] step;
   logic [ACT_W-1:0] seed;
   pat_status_type status;

   // Handshake: the request stage only waits when a result cannot be stored.
   assign s1_is_end   = (s1_req_ff.operation == OP_END);
   assign s1_go       = s1_valid_ff && (!s1_is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_go;
   assign accept      = req_valid && req_ready;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);
   assign s1_req_in   = accept ? req_payload : s1_req_ff;

   wgm_pattern u_pattern (
      .clock  (clock),
      .reset  (reset),
      .upd    (s1_go),
      .req    (s1_req_ff),
      .status (status)
   );

   // On a text byte, advance every active position whose byte matches and keep active stars; otherwise restart at zero.
   assign step = {1'b0, act_ff[MAX_PATTERN-1:0] & status.star_now} |
                 {act_ff[MAX_PATTERN-1:0] & status.hit_now, 1'b0};
   assign seed = (s1_req_ff.operation == OP_TEXT) ? step : ACT_W'(1);
   assign act_in = s1_go ? star_closure(seed, status.star_next) : act_ff;

   // Result register, loaded on end of text.
   assign rsp_valid_in = (s1_go && s1_is_end) || (rsp_valid_ff && !rsp_ready);
   always_comb begin
      rsp_in = rsp_ff;
      if (s1_go && s1_is_end) begin
         rsp_in.matched          = act_ff[status.length];
         rsp_in.pattern_overflow = status.overflow;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= ACT_W'(1);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/wgm_checker.sv @@
// Port-level checker for the glob matcher and its bind statement.
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input wgm_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready
);
   import wgm_pkg::*;

   logic end_accept;

   // An end of text request taken at this edge.
   assign end_accept = req_valid && req_ready && (req_payload.operation == OP_END);

   // A response that is not taken stays offered.
   `WGM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)

   // Reset leaves no response behind.
   `WGM_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // A fresh response follows an accepted end of text through the request and response registers.
   `WGM_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(end_accept, 2))

   // Requests are only held off while a response is stalled.
   `WGM_ASSERT(a_ready_cause, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready))

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);
